// ===== hw/rtl/nat_header_translator_macros.svh =====
// assertion macros for the nat header translator checker
// no dependencies
`ifndef NAT_HEADER_TRANSLATOR_MACROS_SVH
`define NAT_HEADER_TRANSLATOR_MACROS_SVH
// implication checked on every clock edge outside reset
`define NAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nat check failed");
// next-cycle implication checked outside reset
`define NAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nat check failed");
`endif

// ===== hw/rtl/nat_pkg.sv =====
// package for the nat header translator: constants, types, checksum helpers
// no dependencies
package nat_pkg;
  localparam int unsigned NatEntries = 256;
  localparam logic [15:0] PortMinReset = 16'd32000;
  localparam logic [15:0] PortMaxReset = 16'd65000;
  localparam logic [15:0] CsumMangled0 = 16'hFFFF;
  localparam logic [7:0] IpprotoTcp = 8'd6;
  localparam logic [7:0] IpprotoUdp = 8'd17;
  localparam logic [7:0] IpprotoIcmp = 8'd1;
  localparam logic [1:0] StEgressOk = 2'd0;
  localparam logic [1:0] StEgressFull = 2'd1;
  localparam logic [1:0] StIngressOk = 2'd2;
  localparam logic [1:0] StIngressMiss = 2'd3;
  localparam logic CfgPortMin = 1'b0;
  localparam logic CfgPortMax = 1'b1;

  typedef struct packed {
    logic        action;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  proto;
    logic [15:0] l4_checksum;
    logic [15:0] ip_checksum;
    logic [31:0] egress_ip;
    logic        flow_mapped;
    logic [15:0] flow_port;
  } item_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_src_ip;
    logic [31:0] out_dst_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [15:0] out_l4_checksum;
    logic [15:0] out_ip_checksum;
    logic [15:0] assigned_port;
  } item_out_t;

  typedef struct packed {
    logic load;     // latch a new item
    logic egress;   // finish an egress item
    logic scan;     // compare the registered entry and step
    logic finish;   // build ingress result
    logic rd;       // issue a table read
  } nat_cmd_t;

  typedef struct packed {
    logic is_ingress;
    logic empty;    // nothing to search
    logic hit;      // registered entry matched
    logic last;     // index reached zero
  } nat_sts_t;

  // fold the carries of a 20-bit sum into a 16-bit ones' complement sum of one word
  function automatic logic [15:0] fold(input logic [19:0] s);
    logic [16:0] t;
    logic [15:0] u;
    begin
      t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
      u = t[15:0] + {15'd0, t[16]};
      fold = u;
    end
  endfunction

  // incremental update of ck over word changes a->b for up to three words
  function automatic logic [15:0] csum_upd(input logic [15:0] ck,
      input logic [15:0] a0, input logic [15:0] b0, input logic [15:0] a1,
      input logic [15:0] b1, input logic [15:0] a2, input logic [15:0] b2);
    logic [19:0] s;
    begin
      s = {4'd0, ~ck} + {4'd0, ~a0} + {4'd0, b0} + {4'd0, ~a1} + {4'd0, b1}
        + {4'd0, ~a2} + {4'd0, b2};
      csum_upd = ~fold(s);
    end
  endfunction
endpackage

// ===== hw/rtl/nat_ctrl.sv =====
// controller state machine for the nat header translator
// depends on nat_pkg
module nat_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output nat_pkg::nat_cmd_t   cmd,
  input  nat_pkg::nat_sts_t   sts
);
  typedef enum logic [2:0] {S_IDLE, S_DISP, S_RD, S_CMP, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic vld_r, vld_nxt;

  always_comb begin
    state_nxt = state_r;
    vld_nxt = vld_r;
    cmd = '0;
    if (vld_r && res_ready) vld_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        if (!sts.is_ingress) begin
          if (!vld_nxt) begin
            cmd.egress = 1'b1; vld_nxt = 1'b1; state_nxt = S_IDLE;
          end
        end else if (sts.empty) begin
          state_nxt = S_OUT;
        end else begin
          cmd.rd = 1'b1; state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.last) state_nxt = S_OUT;
        else begin
          cmd.rd = 1'b1; state_nxt = S_RD;
        end
      end
      S_OUT: if (!vld_nxt) begin
        cmd.finish = 1'b1; vld_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign res_valid = vld_r;
endmodule

// ===== hw/rtl/nat_dp.sv =====
// datapath for the nat header translator: port counter, table, checksums
// depends on nat_pkg
module nat_dp #(
  parameter int unsigned NAT_ENTRIES = nat_pkg::NatEntries
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [15:0]         cfg_data,
  input  nat_pkg::item_in_t   item,
  input  nat_pkg::nat_cmd_t   cmd,
  output nat_pkg::nat_sts_t   sts,
  output nat_pkg::item_out_t  res
);
  localparam int unsigned AW = (NAT_ENTRIES > 1) ? $clog2(NAT_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(NAT_ENTRIES + 1);
  localparam int unsigned EW = 32 + 32 + 40 + 48;

  logic [15:0] port_min_r, port_max_r, next_port_r;
  logic [CW-1:0] count_r;
  nat_pkg::item_in_t it_r;
  logic [CW-1:0] idx_r;
  logic [EW-1:0] mem [NAT_ENTRIES];
  logic [EW-1:0] rd_r;
  logic hit_r, hit_nxt;
  logic [EW-1:0] ent_r;
  nat_pkg::item_out_t res_r;

  logic l4p, icmp;
  assign l4p = (it_r.proto == nat_pkg::IpprotoTcp) || (it_r.proto == nat_pkg::IpprotoUdp);
  assign icmp = it_r.proto == nat_pkg::IpprotoIcmp;

  // port allocation
  logic [15:0] take, np_nxt, p1, newport, oldport, remport, l4e;
  always_comb begin
    p1 = next_port_r + 16'd1;
    if (next_port_r < port_min_r) begin
      take = port_min_r;
      np_nxt = port_min_r + 16'd1;
    end else begin
      take = next_port_r;
      np_nxt = ({1'b0, next_port_r} + 17'd1 > {1'b0, port_max_r}) ? port_min_r : p1;
    end
    newport = it_r.flow_mapped ? it_r.flow_port : take;
    oldport = l4p ? it_r.src_port : 16'd0;
    remport = l4p ? it_r.dst_port : 16'd0;
    if (!l4p && icmp) newport = 16'd0;
    l4e = nat_pkg::csum_upd(it_r.l4_checksum, it_r.src_ip[31:16], it_r.egress_ip[31:16],
      it_r.src_ip[15:0], it_r.egress_ip[15:0], oldport, newport);
  end

  // search key
  logic [39:0] kpp;
  logic match;
  assign kpp = {l4p ? it_r.dst_port : 16'd0, l4p ? it_r.src_port : 16'd0, it_r.proto};
  assign match = rd_r[151:120] == it_r.dst_ip && rd_r[119:88] == it_r.src_ip
      && rd_r[87:48] == kpp;

  always_comb begin
    hit_nxt = hit_r;
    if (cmd.load) hit_nxt = 1'b0;
    else if (cmd.scan && match) hit_nxt = 1'b1;
  end

  logic full;
  assign full = count_r == CW'(NAT_ENTRIES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_min_r <= nat_pkg::PortMinReset;
      port_max_r <= nat_pkg::PortMaxReset;
      next_port_r <= '0;
      count_r <= '0;
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
      if (cfg_we) begin
        if (cfg_idx == nat_pkg::CfgPortMin) port_min_r <= cfg_data;
        else port_max_r <= cfg_data;
      end
      if (cmd.egress && !it_r.flow_mapped) begin
        next_port_r <= np_nxt;
        if (!full) count_r <= count_r + CW'(1);
      end
    end
  end

  // the ip checksum covers two words; the spare pair ffff->0000 adds nothing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_r <= item;
      idx_r <= count_r;
    end
    if (cmd.rd) begin
      rd_r <= mem[AW'(idx_r - CW'(1))];
      idx_r <= idx_r - CW'(1);
    end
    if (cmd.scan && match && !hit_r) ent_r <= rd_r;
    if (cmd.egress && !it_r.flow_mapped && !full)
      mem[AW'(count_r)] <= {it_r.egress_ip, it_r.dst_ip, newport, remport, it_r.proto,
                            it_r.src_ip, oldport};
    if (cmd.egress) begin
      res_r.status <= (!it_r.flow_mapped && full) ? nat_pkg::StEgressFull
                                                   : nat_pkg::StEgressOk;
      res_r.out_src_ip <= it_r.egress_ip;
      res_r.out_dst_ip <= it_r.dst_ip;
      res_r.out_src_port <= l4p ? newport : it_r.src_port;
      res_r.out_dst_port <= it_r.dst_port;
      res_r.out_l4_checksum <= !l4p ? it_r.l4_checksum
                             : (l4e == 16'd0) ? nat_pkg::CsumMangled0 : l4e;
      res_r.out_ip_checksum <= nat_pkg::csum_upd(it_r.ip_checksum, it_r.src_ip[31:16],
        it_r.egress_ip[31:16], it_r.src_ip[15:0], it_r.egress_ip[15:0], 16'hFFFF, 16'd0);
      res_r.assigned_port <= newport;
    end
    if (cmd.finish) begin
      res_r.out_src_ip <= it_r.src_ip;
      res_r.out_src_port <= it_r.src_port;
      res_r.assigned_port <= '0;
      if (hit_r) begin
        res_r.status <= nat_pkg::StIngressOk;
        res_r.out_dst_ip <= ent_r[47:16];
        res_r.out_dst_port <= l4p ? ent_r[15:0] : it_r.dst_port;
        res_r.out_l4_checksum <= !l4p ? it_r.l4_checksum
          : nat_pkg::csum_upd(it_r.l4_checksum, ent_r[151:136], ent_r[47:32],
              ent_r[135:120], ent_r[31:16], ent_r[87:72], ent_r[15:0]);
        res_r.out_ip_checksum <= nat_pkg::csum_upd(it_r.ip_checksum, it_r.dst_ip[31:16],
          ent_r[47:32], it_r.dst_ip[15:0], ent_r[31:16], 16'hFFFF, 16'd0);
      end else begin
        res_r.status <= nat_pkg::StIngressMiss;
        res_r.out_dst_ip <= it_r.dst_ip;
        res_r.out_dst_port <= it_r.dst_port;
        res_r.out_l4_checksum <= it_r.l4_checksum;
        res_r.out_ip_checksum <= it_r.ip_checksum;
      end
    end
  end

  assign sts.is_ingress = it_r.action;
  assign sts.empty = idx_r == '0;
  assign sts.hit = match;
  assign sts.last = idx_r == '0;
  assign res = res_r;
endmodule

// ===== hw/rtl/nat_header_translator.sv =====
// top level of the nat header translator: stream ports, controller, datapath
// depends on nat_pkg, nat_ctrl, nat_dp
// Source NAT of one IPv4 header tuple per item. Egress items are accepted,
// then dispatched into the result register; ingress items search the
// translation table newest entry first through a single memory read port
// (256 entries by default), reading each entry and then comparing it. One
// item is in flight at a time; the result register holds until taken, and a
// held result stalls the dispatch of the next one. The table needs no
// clearing pass: only entries below the fill count are searched.
module nat_header_translator #(
  parameter int unsigned NAT_ENTRIES = nat_pkg::NatEntries
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // action, src_ip, dst_ip, src_port, dst_port, proto, l4_checksum,
  // ip_checksum, egress_ip, flow_mapped, flow_port; zero fill to 192 bits
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, out_src_ip, out_dst_ip, out_src_port, out_dst_port,
  // out_l4_checksum, out_ip_checksum, assigned_port; zero fill to 152 bits
  output logic [151:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_idx,
  input  logic [15:0]  cfg_data
);
  nat_pkg::item_in_t  item;
  nat_pkg::item_out_t res;
  nat_pkg::nat_cmd_t  cmd;
  nat_pkg::nat_sts_t  sts;

  // unpack input fields, first field in the lowest bit
  assign item.action      = in_tdata[0];
  assign item.src_ip      = in_tdata[32:1];
  assign item.dst_ip      = in_tdata[64:33];
  assign item.src_port    = in_tdata[80:65];
  assign item.dst_port    = in_tdata[96:81];
  assign item.proto       = in_tdata[104:97];
  assign item.l4_checksum = in_tdata[120:105];
  assign item.ip_checksum = in_tdata[136:121];
  assign item.egress_ip   = in_tdata[168:137];
  assign item.flow_mapped = in_tdata[169];
  assign item.flow_port   = in_tdata[185:170];

  assign out_tdata = {6'd0, res.assigned_port, res.out_ip_checksum, res.out_l4_checksum,
                      res.out_dst_port, res.out_src_port, res.out_dst_ip,
                      res.out_src_ip, res.status};

  nat_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid), .in_ready(in_tready),
    .res_valid(out_tvalid), .res_ready(out_tready), .cmd(cmd), .sts(sts)
  );

  nat_dp #(.NAT_ENTRIES(NAT_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_data(cfg_data), .item(item), .cmd(cmd), .sts(sts), .res(res)
  );
endmodule

// ===== hw/rtl/nat_chk.sv =====
// port checker for the nat header translator, bound to the top level
// depends on nat_header_translator_macros.svh
`include "nat_header_translator_macros.svh"
module nat_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [151:0] out_tdata
);
  // a result stalled by the sink holds its data
  `NAT_ASSERT_NXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // no new item is taken the cycle after one is accepted
  `NAT_ASSERT_NXT(a_one, in_tvalid && in_tready, !in_tready)
  // a result never appears the cycle right after acceptance
  `NAT_ASSERT_NXT(a_lat, in_tvalid && in_tready && !out_tvalid, !out_tvalid)
endmodule

bind nat_header_translator nat_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
